/* hdl/bpt_pkg.sv */
package bpt_pkg;

    localparam int NUM_SLOTS_DEF = 32;
    localparam int DISK_SIZE_DEF = 8192;

    localparam int REQ_W      = 2;
    localparam int BLK_W      = 16;
    localparam int STATUS_W   = 2;
    localparam int SLOT_IDX_W = 5;
    localparam int WB_BLK_W   = 13;
    localparam int AGE_W      = 6;

    localparam logic [AGE_W-1:0] AGE_MAX = '1;

    localparam logic [REQ_W-1:0] REQ_ALLOC  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DIRTY  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISS  = 2'd2;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic [BLK_W-1:0] block_num;
    } bpt_in_t;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [SLOT_IDX_W-1:0] slot_index;
        logic                  writeback_valid;
        logic [WB_BLK_W-1:0]   writeback_block;
    } bpt_out_t;

    // search record handed from cell to cell
    typedef struct packed {
        logic             free_found;
        logic             best_found;
        logic             best_dirty;
        logic [AGE_W-1:0] best_age;
        logic             hit_found;
    } bpt_rec_t;

    // update broadcast to all cells at the end of a request
    typedef struct packed {
        logic en;
        logic alloc;
        logic mark;
    } bpt_cmt_t;

endpackage

/* hdl/bpt_cell.sv */
module bpt_cell
    import bpt_pkg::*;
#(
    parameter int IW       = 5,
    parameter int BW       = 13,
    parameter int CELL_IDX = 0
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [REQ_W-1:0] req,
    input  logic [BW-1:0]    blk,
    input  logic             in_tok,
    input  bpt_rec_t         in_rec,
    input  logic [IW-1:0]    in_free_idx,
    input  logic [IW-1:0]    in_best_idx,
    input  logic [IW-1:0]    in_hit_idx,
    input  logic [BW-1:0]    in_best_block,
    output logic             out_tok,
    output bpt_rec_t         out_rec,
    output logic [IW-1:0]    out_free_idx,
    output logic [IW-1:0]    out_best_idx,
    output logic [IW-1:0]    out_hit_idx,
    output logic [BW-1:0]    out_best_block,
    input  bpt_cmt_t         cmt,
    input  logic [IW-1:0]    cmt_idx
);

    localparam logic [IW-1:0] MY_IDX = IW'(CELL_IDX);

    logic             valid_reg;
    logic             dirty_reg;
    logic [AGE_W-1:0] age_reg;
    logic [BW-1:0]    block_reg;
    logic             tok_reg;
    bpt_rec_t         rec_reg;
    logic [IW-1:0]    free_idx_reg;
    logic [IW-1:0]    best_idx_reg;
    logic [IW-1:0]    hit_idx_reg;
    logic [BW-1:0]    best_block_reg;

    bpt_rec_t         rec_next;
    logic [IW-1:0]    free_idx_next;
    logic [IW-1:0]    best_idx_next;
    logic [IW-1:0]    hit_idx_next;
    logic [BW-1:0]    best_block_next;
    logic [AGE_W-1:0] aged;
    logic             is_alloc;
    logic             hit;
    logic             mine;

    assign is_alloc = (req == REQ_ALLOC);
    assign hit      = valid_reg && (block_reg == blk);
    assign aged     = (valid_reg && age_reg != AGE_MAX) ? age_reg + AGE_W'(1) : age_reg;
    assign mine     = cmt.en && (cmt_idx == MY_IDX);

    always_comb begin
        rec_next        = in_rec;
        free_idx_next   = in_free_idx;
        best_idx_next   = in_best_idx;
        hit_idx_next    = in_hit_idx;
        best_block_next = in_best_block;
        if (is_alloc) begin
            if (!in_rec.free_found && !valid_reg) begin
                rec_next.free_found = 1'b1;
                free_idx_next       = MY_IDX;
            end
            if (!in_rec.best_found || aged > in_rec.best_age) begin
                rec_next.best_found = 1'b1;
                rec_next.best_age   = aged;
                rec_next.best_dirty = dirty_reg;
                best_idx_next       = MY_IDX;
                best_block_next     = block_reg;
            end
        end else if (!in_rec.hit_found && hit) begin
            rec_next.hit_found = 1'b1;
            hit_idx_next       = MY_IDX;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            dirty_reg <= 1'b0;
            age_reg   <= '0;
            tok_reg   <= 1'b0;
        end else begin
            tok_reg <= in_tok;
            if (in_tok && is_alloc) begin
                age_reg <= aged;
            end
            if (mine && cmt.alloc) begin
                valid_reg <= 1'b1;
                dirty_reg <= 1'b0;
                age_reg   <= '0;
            end
            if (mine && cmt.mark) begin
                dirty_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mine && cmt.alloc) begin
            block_reg <= blk;
        end
        if (in_tok) begin
            rec_reg        <= rec_next;
            free_idx_reg   <= free_idx_next;
            best_idx_reg   <= best_idx_next;
            hit_idx_reg    <= hit_idx_next;
            best_block_reg <= best_block_next;
        end
    end

    assign out_tok        = tok_reg;
    assign out_rec        = rec_reg;
    assign out_free_idx   = free_idx_reg;
    assign out_best_idx   = best_idx_reg;
    assign out_hit_idx    = hit_idx_reg;
    assign out_best_block = best_block_reg;

endmodule

/* hdl/buffer_pool_tag_manager.sv */
// Allocate, lookup and mark-dirty: a sweep token walks the row of slot cells, one cell per cycle,
// then the pick is committed; the block takes one request at a time.
// Out-of-bound and unused request codes skip the sweep and commit nothing to the slot cells.
// Synchronous active-low reset: every slot free, clean, age zero; ready once reset is released.
module buffer_pool_tag_manager
    import bpt_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF,
    parameter int DISK_SIZE = DISK_SIZE_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  bpt_in_t  s_word,
    output logic     m_valid,
    input  logic     m_ready,
    output bpt_out_t m_word
);

    localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int BW = (DISK_SIZE > 1) ? $clog2(DISK_SIZE) : 1;
    localparam logic [BLK_W:0] DISK_LIM = (BLK_W + 1)'(DISK_SIZE);

    typedef enum logic [1:0] {IDLE, SWEEP, DONE} state_t;

    state_t              state_reg;
    logic                start_reg;
    logic [REQ_W-1:0]    req_reg;
    logic [BW-1:0]       blk_reg;
    logic                bypass_reg;
    logic [STATUS_W-1:0] bypass_status_reg;
    logic                m_valid_reg;
    bpt_out_t            m_word_reg;

    logic     tok        [NUM_SLOTS+1];
    bpt_rec_t rec        [NUM_SLOTS+1];
    logic [IW-1:0] free_idx [NUM_SLOTS+1];
    logic [IW-1:0] best_idx [NUM_SLOTS+1];
    logic [IW-1:0] hit_idx  [NUM_SLOTS+1];
    logic [BW-1:0] best_blk [NUM_SLOTS+1];

    bpt_cmt_t      cmt;
    logic [IW-1:0] cmt_idx;
    bpt_out_t      res;
    logic          out_free;
    logic          finish;
    logic          accept;
    logic          in_bound;
    bpt_rec_t      end_rec;

    assign tok[0]      = start_reg;
    assign rec[0]      = '0;
    assign free_idx[0] = '0;
    assign best_idx[0] = '0;
    assign hit_idx[0]  = '0;
    assign best_blk[0] = '0;

    for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
        bpt_cell #(
            .IW       (IW),
            .BW       (BW),
            .CELL_IDX (g)
        ) u_cell (
            .aclk           (aclk),
            .aresetn        (aresetn),
            .req            (req_reg),
            .blk            (blk_reg),
            .in_tok         (tok[g]),
            .in_rec         (rec[g]),
            .in_free_idx    (free_idx[g]),
            .in_best_idx    (best_idx[g]),
            .in_hit_idx     (hit_idx[g]),
            .in_best_block  (best_blk[g]),
            .out_tok        (tok[g+1]),
            .out_rec        (rec[g+1]),
            .out_free_idx   (free_idx[g+1]),
            .out_best_idx   (best_idx[g+1]),
            .out_hit_idx    (hit_idx[g+1]),
            .out_best_block (best_blk[g+1]),
            .cmt            (cmt),
            .cmt_idx        (cmt_idx)
        );
    end

    assign end_rec  = rec[NUM_SLOTS];
    assign s_ready  = aresetn && (state_reg == IDLE);
    assign accept   = s_valid && s_ready;
    assign in_bound = {1'b0, s_word.block_num} < DISK_LIM;
    assign out_free = !m_valid_reg || m_ready;
    assign finish   = out_free
                      && ((state_reg == SWEEP && tok[NUM_SLOTS]) || state_reg == DONE);

    always_comb begin
        res       = '0;
        cmt.alloc = 1'b0;
        cmt.mark  = 1'b0;
        cmt_idx   = hit_idx[NUM_SLOTS];
        if (bypass_reg) begin
            res.status = bypass_status_reg;
        end else begin
            case (req_reg)
                REQ_ALLOC: begin
                    cmt.alloc = 1'b1;
                    cmt_idx   = end_rec.free_found ? free_idx[NUM_SLOTS] : best_idx[NUM_SLOTS];
                    res.slot_index = SLOT_IDX_W'(cmt_idx);
                    if (!end_rec.free_found && end_rec.best_dirty) begin
                        res.writeback_valid = 1'b1;
                        res.writeback_block = WB_BLK_W'(best_blk[NUM_SLOTS]);
                    end
                end
                REQ_LOOKUP, REQ_DIRTY: begin
                    if (end_rec.hit_found) begin
                        res.slot_index = SLOT_IDX_W'(hit_idx[NUM_SLOTS]);
                        cmt.mark       = (req_reg == REQ_DIRTY);
                    end else begin
                        res.status = ST_MISS;
                    end
                end
                default: begin
                    res.status = ST_MISS;
                end
            endcase
        end
        cmt.en = finish && !bypass_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= IDLE;
            start_reg         <= 1'b0;
            req_reg           <= REQ_ALLOC;
            blk_reg           <= '0;
            bypass_reg        <= 1'b0;
            bypass_status_reg <= ST_OK;
            m_valid_reg       <= 1'b0;
            m_word_reg        <= '0;
        end else begin
            start_reg <= 1'b0;
            case (state_reg)
                IDLE: begin
                    if (accept) begin
                        req_reg <= s_word.req_type;
                        blk_reg <= BW'(s_word.block_num);
                        if (s_word.req_type != REQ_ALLOC && s_word.req_type != REQ_LOOKUP
                            && s_word.req_type != REQ_DIRTY) begin
                            bypass_reg        <= 1'b1;
                            bypass_status_reg <= ST_MISS;
                            state_reg         <= DONE;
                        end else if (!in_bound) begin
                            bypass_reg        <= 1'b1;
                            bypass_status_reg <= ST_BOUND;
                            state_reg         <= DONE;
                        end else begin
                            bypass_reg <= 1'b0;
                            start_reg  <= 1'b1;
                            state_reg  <= SWEEP;
                        end
                    end
                end
                SWEEP: begin
                    if (tok[NUM_SLOTS]) begin
                        state_reg <= finish ? IDLE : DONE;
                    end
                end
                DONE: begin
                    if (finish) begin
                        state_reg <= IDLE;
                    end
                end
                default: begin
                    state_reg <= IDLE;
                end
            endcase
            if (finish) begin
                m_valid_reg <= 1'b1;
                m_word_reg  <= res;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

endmodule

/* hdl/bpt_chk.sv */
module bpt_chk
    import bpt_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input bpt_in_t  s_word,
    input logic     m_valid,
    input logic     m_ready,
    input bpt_out_t m_word
);

    // failed request carries no slot and no write-back
    a_fail_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_word.status != ST_OK)
        |-> (m_word.slot_index == '0 && !m_word.writeback_valid))
        else $error("failed request with slot or write-back");

    // write-back word carries no stray block bits when not flagged
    a_wb_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_word.writeback_valid) |-> (m_word.writeback_block == '0))
        else $error("write-back block set without write-back");

    // one request at a time: no accept right after an accept
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while request in flight");

    // stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_word)))
        else $error("result word changed while stalled");

endmodule

bind buffer_pool_tag_manager bpt_chk u_bpt_chk (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_word  (s_word),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_word  (m_word)
);

/* test/buffer_pool_tag_manager_test.sv */
`timescale 1ns / 1ps

module buffer_pool_tag_manager_test;
    import bpt_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int POOL_SIZE = 40;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 40;

    class tag_scoreboard;
        bit                  occupied[NUM_SLOTS_DEF];
        bit                  modified[NUM_SLOTS_DEF];
        logic [AGE_W-1:0]    stamp[NUM_SLOTS_DEF];
        logic [WB_BLK_W-1:0] tag_block[NUM_SLOTS_DEF];
        bpt_out_t            expected_replies[$];
        int                  errors;

        function new();
            for (int i = 0; i < NUM_SLOTS_DEF; i++) begin
                occupied[i] = 1'b0;
                modified[i] = 1'b0;
                stamp[i] = '0;
                tag_block[i] = '0;
            end
            errors = 0;
        endfunction

        function int pending();
            return expected_replies.size();
        endfunction

        function bpt_out_t resolve_request(bpt_in_t w);
            bpt_out_t r;
            int pick;
            int oldest;
            r = '0;
            pick = -1;
            if (w.req_type == REQ_UNUSED) begin
                r.status = ST_MISS;
            end else if (w.block_num >= DISK_SIZE_DEF) begin
                r.status = ST_BOUND;
            end else if (w.req_type == REQ_ALLOC) begin
                for (int i = 0; i < NUM_SLOTS_DEF; i++) begin
                    if (occupied[i] && stamp[i] != AGE_MAX)
                        stamp[i] = stamp[i] + 1'b1;
                end
                for (int i = 0; i < NUM_SLOTS_DEF; i++) begin
                    if (!occupied[i] && pick < 0)
                        pick = i;
                end
                if (pick < 0) begin
                    oldest = -1;
                    for (int i = 0; i < NUM_SLOTS_DEF; i++) begin
                        if (int'(stamp[i]) > oldest) begin
                            oldest = int'(stamp[i]);
                            pick = i;
                        end
                    end
                    if (modified[pick]) begin
                        r.writeback_valid = 1'b1;
                        r.writeback_block = tag_block[pick];
                    end
                end
                occupied[pick] = 1'b1;
                modified[pick] = 1'b0;
                stamp[pick] = '0;
                tag_block[pick] = w.block_num[WB_BLK_W-1:0];
                r.slot_index = pick[SLOT_IDX_W-1:0];
            end else begin
                for (int i = 0; i < NUM_SLOTS_DEF; i++) begin
                    if (pick < 0 && occupied[i] && tag_block[i] == w.block_num[WB_BLK_W-1:0])
                        pick = i;
                end
                if (pick < 0) begin
                    r.status = ST_MISS;
                end else begin
                    r.slot_index = pick[SLOT_IDX_W-1:0];
                    if (w.req_type == REQ_DIRTY)
                        modified[pick] = 1'b1;
                end
            end
            return r;
        endfunction

        function void note_request(bpt_in_t w);
            expected_replies.push_back(resolve_request(w));
        endfunction

        task report(string msg);
            $display("MISMATCH %s", msg);
            errors++;
        endtask

        task check_result(bpt_out_t got);
            bpt_out_t want;
            if (expected_replies.size() == 0) begin
                report($sformatf("word with nothing outstanding: %h", got));
            end else begin
                want = expected_replies.pop_front();
                if (got.status !== want.status)
                    report($sformatf("status got %0d want %0d", got.status, want.status));
                if (got.slot_index !== want.slot_index)
                    report($sformatf("slot_index got %0d want %0d",
                                     got.slot_index, want.slot_index));
                if (got.writeback_valid !== want.writeback_valid)
                    report($sformatf("writeback_valid got %0d want %0d",
                                     got.writeback_valid, want.writeback_valid));
                if (got.writeback_block !== want.writeback_block)
                    report($sformatf("writeback_block got %0d want %0d",
                                     got.writeback_block, want.writeback_block));
            end
        endtask
    endclass

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    bpt_in_t  s_word = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    bpt_out_t m_word;

    tag_scoreboard sb;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  quiet_cycles = 0;
    int  hold_left = 0;
    bit  hold_req = 1'b0;
    bit  hold_ack = 1'b0;
    logic [BLK_W-1:0] block_pool[POOL_SIZE];

    buffer_pool_tag_manager u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (hold_req != hold_ack) begin
            hold_ack <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // record accepted words on both channels
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note_request(s_word);
            if (m_valid && m_ready)
                sb.check_result(m_word);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        while (quiet_cycles < STALL_LIMIT)
            @(posedge aclk);
        $display("buffer_pool_tag_manager verification failed");
        $finish;
    end

    task automatic issue(input logic [REQ_W-1:0] kind, input logic [BLK_W-1:0] blk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_word <= '{req_type: kind, block_num: blk};
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    task automatic run_random(input int send_pct, input int recv_pct, input int count,
                              input bit squeeze);
        int r;
        logic [REQ_W-1:0] kind;
        logic [BLK_W-1:0] blk;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(99);
            if (r < 38) begin
                kind = REQ_ALLOC;
                blk = block_pool[$urandom_range(POOL_SIZE-1)];
            end else if (r < 62) begin
                kind = REQ_LOOKUP;
                blk = block_pool[$urandom_range(POOL_SIZE-1)];
            end else if (r < 86) begin
                kind = REQ_DIRTY;
                blk = block_pool[$urandom_range(POOL_SIZE-1)];
            end else if (r < 94) begin
                kind = REQ_W'($urandom_range(2));
                blk = BLK_W'($urandom_range(65535, DISK_SIZE_DEF));
            end else if (r < 97) begin
                kind = REQ_UNUSED;
                blk = BLK_W'($urandom);
            end else begin
                kind = REQ_W'($urandom_range(2));
                blk = BLK_W'($urandom_range(DISK_SIZE_DEF-1));
            end
            if (squeeze && n == count/4)
                hold_req <= ~hold_req;
            issue(kind, blk);
        end
    endtask

    initial begin
        sb = new();
        for (int i = 0; i < POOL_SIZE; i++)
            block_pool[i] = BLK_W'($urandom_range(DISK_SIZE_DEF-1));
        block_pool[0] = '0;
        block_pool[1] = BLK_W'(DISK_SIZE_DEF-1);
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 33;
        recv_idle_pct = 47;
        issue(REQ_LOOKUP, 16'h0000);
        issue(REQ_DIRTY, 16'h0000);
        issue(REQ_ALLOC, 16'h0000);
        issue(REQ_ALLOC, 16'h1FFF);
        issue(REQ_ALLOC, 16'h2000);
        issue(REQ_ALLOC, 16'hFFFF);
        issue(REQ_LOOKUP, 16'hFFFF);
        issue(REQ_DIRTY, 16'h2000);
        issue(REQ_UNUSED, 16'h0000);
        issue(REQ_UNUSED, 16'hFFFF);
        issue(REQ_UNUSED, 16'h1FFF);
        issue(REQ_LOOKUP, 16'h1FFF);
        issue(REQ_DIRTY, 16'h1FFF);
        issue(REQ_ALLOC, 16'h0000);
        issue(REQ_LOOKUP, 16'h0000);
        issue(REQ_DIRTY, 16'h0000);
        issue(REQ_LOOKUP, 16'h1234);
        issue(REQ_ALLOC, 16'h0AAA);
        issue(REQ_ALLOC, 16'h1555);
        issue(REQ_LOOKUP, 16'h1555);
        issue(REQ_DIRTY, 16'h0AAA);
        issue(REQ_ALLOC, 16'hAAAA);
        issue(REQ_LOOKUP, 16'h5555);
        wait_drained();

        run_random(33, 47, 210, 1'b0);
        wait_drained();
        run_random(47, 33, 210, 1'b0);
        wait_drained();
        run_random(0, 0, 210, 1'b1);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("buffer_pool_tag_manager verification clean");
        else
            $display("buffer_pool_tag_manager verification failed");
        $finish;
    end

endmodule
